[src/skprd_pkg.sv]
// Shared types, constants and the nibble character table of the packet run decoder.
package skprd_pkg;

	// Session transform constants.
	localparam logic [7:0] KEY_OFFSET   = 8'h40;
	localparam logic [7:0] MODE_XOR     = 8'hC3;

	// Byte codes and masks of the packet format.
	localparam logic [7:0] SEP_BYTE     = 8'hFF;
	localparam logic [7:0] ZERO_BYTE    = 8'h00;
	localparam logic [7:0] RAW_HDR_MAX  = 8'h7A;
	localparam logic [7:0] PACKED_MASK  = 8'h7F;
	localparam logic [7:0] RAW_XOR      = 8'hFF;
	localparam logic [3:0] NIB_SKIP_LO  = 4'h0;
	localparam logic [3:0] NIB_SKIP_HI  = 4'hF;

	// Kinds of result item.
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Number of result slots one input byte can fill.
	localparam int unsigned NUM_SLOTS = 3;

	// Slot positions in emission order.
	localparam int unsigned SLOT_FIRST  = 0;
	localparam int unsigned SLOT_SECOND = 1;
	localparam int unsigned SLOT_END    = 2;

	// Decoder phase, one-hot.
	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_RAW    = 4'b0010,
		PH_PACKED = 4'b0100,
		PH_STOP   = 4'b1000
	} phase_t;

	// Result items produced by one input byte, in output order.
	typedef struct packed {
		logic [NUM_SLOTS-1:0]      valid;
		logic [NUM_SLOTS-1:0][7:0] chars;
		logic [NUM_SLOTS-1:0]      kinds;
	} result_set_t;

	// Character for a packed nibble in the range 1 to 14.
	function automatic logic [7:0] nibble_char(input logic [3:0] nib);
		logic [7:0] ch;
		unique case (nib)
			4'h1:    ch = 8'h20; // space
			4'h2:    ch = 8'h2D; // minus
			4'h3:    ch = 8'h2E; // dot
			4'h4:    ch = 8'h30;
			4'h5:    ch = 8'h31;
			4'h6:    ch = 8'h32;
			4'h7:    ch = 8'h33;
			4'h8:    ch = 8'h34;
			4'h9:    ch = 8'h35;
			4'hA:    ch = 8'h36;
			4'hB:    ch = 8'h37;
			4'hC:    ch = 8'h38;
			4'hD:    ch = 8'h39;
			4'hE:    ch = 8'h6E; // letter n
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

[src/skprd_decode.sv]
// Session transform and per-byte decode: result items and next run state.
module skprd_decode import skprd_pkg::*; (
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic [7:0]  session,
	input  phase_t      phase,
	input  logic [7:0]  remain,
	output result_set_t results,
	output phase_t      nxt_phase,
	output logic [7:0]  nxt_remain
);

	logic [7:0] key;
	logic [7:0] plain;
	logic [3:0] hi_nib;
	logic [3:0] lo_nib;
	logic       hi_ok;
	logic       lo_ok;
	logic [1:0] taken;
	logic [7:0] packed_len;

	// Session key and cipher mode.
	always_comb begin
		key = session + KEY_OFFSET;
		if (session[6]) begin
			plain = data_byte + key;
		end else begin
			plain = data_byte - key;
		end
		if (session[7]) begin
			plain = plain ^ MODE_XOR;
		end
	end

	assign hi_nib     = plain[7:4];
	assign lo_nib     = plain[3:0];
	assign hi_ok      = (hi_nib != NIB_SKIP_LO) && (hi_nib != NIB_SKIP_HI);
	assign lo_ok      = (lo_nib != NIB_SKIP_LO) && (lo_nib != NIB_SKIP_HI);
	assign taken      = {1'b0, hi_ok} + {1'b0, lo_ok};
	assign packed_len = plain & PACKED_MASK;

	// Result items and run state update for one byte.
	always_comb begin
		results    = '0;
		nxt_phase  = phase;
		nxt_remain = remain;
		if (plain == SEP_BYTE) begin
			results.valid[SLOT_FIRST] = 1'b1;
			results.kinds[SLOT_FIRST] = KIND_END;
			nxt_phase  = PH_HEADER;
			nxt_remain = '0;
		end else begin
			if ((phase != PH_STOP) && (plain == ZERO_BYTE)) begin
				nxt_phase  = PH_STOP;
				nxt_remain = '0;
			end else begin
				unique case (phase)
					PH_HEADER: begin
						if (plain <= RAW_HDR_MAX) begin
							nxt_phase  = PH_RAW;
							nxt_remain = plain;
						end else begin
							nxt_remain = packed_len;
							nxt_phase  = (packed_len != '0) ? PH_PACKED : PH_HEADER;
						end
					end
					PH_RAW: begin
						results.valid[SLOT_FIRST] = 1'b1;
						results.chars[SLOT_FIRST] = plain ^ RAW_XOR;
						results.kinds[SLOT_FIRST] = KIND_CHAR;
						nxt_remain = (remain != '0) ? remain - 8'd1 : '0;
						if (remain <= 8'd1) begin
							nxt_phase = PH_HEADER;
						end
					end
					PH_PACKED: begin
						results.valid[SLOT_FIRST]  = hi_ok;
						results.chars[SLOT_FIRST]  = nibble_char(hi_nib);
						results.kinds[SLOT_FIRST]  = KIND_CHAR;
						results.valid[SLOT_SECOND] = lo_ok;
						results.chars[SLOT_SECOND] = nibble_char(lo_nib);
						results.kinds[SLOT_SECOND] = KIND_CHAR;
						// Saturating count-down; the nibbles that are not skipped are emitted even when they overshoot the count.
						if (remain > {6'd0, taken}) begin
							nxt_remain = remain - {6'd0, taken};
						end else begin
							nxt_remain = '0;
							nxt_phase  = PH_HEADER;
						end
					end
					PH_STOP: begin
						nxt_phase = PH_STOP;
					end
					default: begin
						nxt_phase = PH_HEADER;
					end
				endcase
			end
			// End of the received buffer closes the packet.
			if (last) begin
				results.valid[SLOT_END] = 1'b1;
				results.kinds[SLOT_END] = KIND_END;
				nxt_phase  = PH_HEADER;
				nxt_remain = '0;
			end
		end
	end

endmodule

[src/session_keyed_packet_run_decoder.sv]
// Top level of the session keyed packet run decoder.
// Received bytes enter an input register, are deciphered with the session key and decoded
// in one pass, and their result items (up to three: a separator end marker, or one raw
// character, or up to two packed characters, plus a buffer end marker) are loaded into a
// result register that is drained one item per cycle while out_ready is high. A byte is
// accepted every cycle as long as each byte yields at most one result item and out_ready
// is high; a byte that yields more items holds the result register until they have been
// taken, so the sustained rate is set by the output side. The session register may only
// be written while no item is in flight.
module session_keyed_packet_run_decoder import skprd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       buffer_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       item_kind
);

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic                      last_s1;
	logic [7:0]                session_q;
	phase_t                    phase_q;
	logic [7:0]                remain_q;
	logic [NUM_SLOTS-1:0]      mask_s2;
	logic [NUM_SLOTS-1:0][7:0] chars_s2;
	logic [NUM_SLOTS-1:0]      kinds_s2;

	result_set_t               results;
	phase_t                    nxt_phase;
	logic [7:0]                nxt_remain;
	logic                      in_take;
	logic                      out_take;
	logic                      one_left;
	logic                      s2_free;
	logic                      advance;
	logic [NUM_SLOTS-1:0]      sel_bit;
	logic [1:0]                sel_idx;

	skprd_decode u_decode (
		.data_byte (byte_s1),
		.last      (last_s1),
		.session   (session_q),
		.phase     (phase_q),
		.remain    (remain_q),
		.results   (results),
		.nxt_phase (nxt_phase),
		.nxt_remain(nxt_remain)
	);

	// Handshake and stage advance.
	assign in_take  = in_valid && in_ready;
	assign out_valid = |mask_s2;
	assign out_take = out_valid && out_ready;
	assign one_left = (mask_s2 & (mask_s2 - 3'd1)) == '0;
	assign s2_free  = (mask_s2 == '0) || (out_ready && one_left);
	assign advance  = valid_s1 && ((results.valid == '0) || s2_free);
	assign in_ready = !valid_s1 || advance;

	// Pick the first pending result item.
	assign sel_bit = mask_s2 & (~mask_s2 + 3'd1);
	always_comb begin
		priority if (mask_s2[SLOT_FIRST]) begin
			sel_idx = 2'(SLOT_FIRST);
		end else if (mask_s2[SLOT_SECOND]) begin
			sel_idx = 2'(SLOT_SECOND);
		end else begin
			sel_idx = 2'(SLOT_END);
		end
	end
	assign out_char  = chars_s2[sel_idx];
	assign item_kind = kinds_s2[sel_idx];

	// Session register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q <= '0;
		end else if (cfg_wr_en) begin
			session_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
			last_s1 <= buffer_last;
		end
	end

	// Run state, updated as each byte leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			remain_q <= '0;
		end else if (advance) begin
			phase_q  <= nxt_phase;
			remain_q <= nxt_remain;
		end
	end

	// Result register: pending mask cleared one item at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (advance && (results.valid != '0)) begin
			mask_s2 <= results.valid;
		end else if (out_take) begin
			mask_s2 <= mask_s2 & ~sel_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (results.valid != '0)) begin
			chars_s2 <= results.chars;
			kinds_s2 <= results.kinds;
		end
	end

endmodule

[sim/tb_session_keyed_packet_run_decoder.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the session keyed packet run decoder, with its own decoder model.
module tb_session_keyed_packet_run_decoder;
	import skprd_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned MAX_GAP       = 5;
	localparam int unsigned RANDOM_ITEMS  = 340;
	localparam int unsigned RANDOM_PHASES = 6;

	// Session bits that pick addition over subtraction and the extra xor.
	localparam int unsigned ADD_BIT = 6;
	localparam int unsigned XOR_BIT = 7;

	// Characters for nibbles 1 to 14, first character in the top byte.
	localparam logic [14*8-1:0] NIBBLE_CHARS = " -.0123456789n";

	typedef struct packed {
		logic [7:0] ch;
		logic       kind;
	} dec_item_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       buffer_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_char;
	logic       item_kind;

	// Decoder model state and the characters it still owes the output.
	logic [7:0]  session_q = 8'h00;
	phase_t      phase_q   = PH_HEADER;
	logic [7:0]  owed_q    = 8'h00;
	dec_item_t   due_items[$];

	int unsigned error_count   = 0;
	int unsigned checked_count = 0;
	int unsigned live_count    = 0;
	int unsigned session_count = 0;
	int unsigned cycle_count   = 0;
	bit          tx_calm       = 1'b0;
	bit          rx_calm       = 1'b0;

	session_keyed_packet_run_decoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.buffer_last(buffer_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.item_kind  (item_kind)
	);

	// The clock runs at 50 MHz.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// A hung run ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Removes the session cipher from a received byte.
	function automatic logic [7:0] decipher(input logic [7:0] c);
		logic [7:0] key;
		logic [7:0] v;
		key = session_q + KEY_OFFSET;
		v = session_q[ADD_BIT] ? c + key : c - key;
		if (session_q[XOR_BIT])
			v = v ^ MODE_XOR;
		return v;
	endfunction

	// Applies the session cipher, so that stimulus can be planned in plain bytes.
	function automatic logic [7:0] encipher(input logic [7:0] p);
		logic [7:0] key;
		logic [7:0] v;
		key = session_q + KEY_OFFSET;
		v = session_q[XOR_BIT] ? p ^ MODE_XOR : p;
		return session_q[ADD_BIT] ? v - key : v + key;
	endfunction

	function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
		return NIBBLE_CHARS[(14 - int'(nib)) * 8 +: 8];
	endfunction

	// Appends one expected item at the tail of the queue.
	function automatic void append_due(input dec_item_t it);
		due_items = {due_items, it};
	endfunction

	// A decoded character pays off one owed character, never going below zero.
	function automatic void emit_char(input logic [7:0] ch);
		append_due({ch, KIND_CHAR});
		if (owed_q != 8'h00)
			owed_q = owed_q - 8'h01;
	endfunction

	function automatic void emit_end();
		append_due({8'h00, KIND_END});
	endfunction

	// Advances the decoder model by one received byte and queues what it yields.
	function automatic void decode_byte(input logic [7:0] c, input logic is_last);
		logic [7:0] p;
		logic [3:0] hi;
		logic [3:0] lo;
		p = decipher(c);
		if (p == SEP_BYTE) begin
			emit_end();
			phase_q = PH_HEADER;
			owed_q = 8'h00;
			return;
		end
		if (phase_q != PH_STOP && p == ZERO_BYTE) begin
			phase_q = PH_STOP;
			owed_q = 8'h00;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					if (p <= RAW_HDR_MAX) begin
						phase_q = PH_RAW;
						owed_q = p;
					end else begin
						owed_q = p & PACKED_MASK;
						phase_q = (owed_q != 8'h00) ? PH_PACKED : PH_HEADER;
					end
				end
				PH_RAW: begin
					emit_char(p ^ RAW_XOR);
					if (owed_q == 8'h00)
						phase_q = PH_HEADER;
				end
				PH_PACKED: begin
					hi = p[7:4];
					lo = p[3:0];
					if (hi != NIB_SKIP_LO && hi != NIB_SKIP_HI)
						emit_char(nibble_ascii(hi));
					if (lo != NIB_SKIP_LO && lo != NIB_SKIP_HI)
						emit_char(nibble_ascii(lo));
					if (owed_q == 8'h00)
						phase_q = PH_HEADER;
				end
				default: ;
			endcase
		end
		if (is_last) begin
			emit_end();
			phase_q = PH_HEADER;
			owed_q = 8'h00;
		end
	endfunction

	// Compares every accepted result item with the oldest expected one.
	always @(posedge clk) begin : result_check
		dec_item_t want;
		if (arst_n && out_valid && out_ready) begin
			checked_count++;
			if (due_items.size() == 0) begin
				$error("unexpected item: out_char %h, item_kind %b", out_char, item_kind);
				error_count++;
			end else begin
				want = due_items.pop_front();
				if (out_char !== want.ch) begin
					$error("out_char: expected %h, actual %h", want.ch, out_char);
					error_count++;
				end
				if (item_kind !== want.kind) begin
					$error("item_kind: expected %b, actual %b", want.kind, item_kind);
					error_count++;
				end
			end
		end
	end

	// The result side stalls for a random time before each item, except in calm stretches.
	initial begin : result_sink
		int unsigned hold;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Offers one ciphertext byte after a random gap and models it once accepted.
	task automatic send_byte(input logic [7:0] c, input logic is_last);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= c;
		buffer_last <= is_last;
		do @(posedge clk); while (!in_ready);
		if (phase_q != PH_STOP)
			live_count++;
		decode_byte(c, is_last);
	endtask

	task automatic send_plain(input logic [7:0] p, input logic is_last);
		send_byte(encipher(p), is_last);
	endtask

	// Waits until every expected item has come out and the pipeline has drained.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (due_items.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_session(input logic [7:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		session_q = v;
		session_count++;
	endtask

	// Hand-picked packets under the reset session.
	task automatic test_directed_cases();
		// Empty packet.
		send_plain(SEP_BYTE, 1'b0);
		// Raw run with the smallest and largest plain data.
		send_plain(8'h02, 1'b0);
		send_plain(8'h01, 1'b0);
		send_plain(8'hFE, 1'b0);
		// Packed run with skipped nibbles, ending in a byte that overshoots.
		send_plain(8'h83, 1'b0);
		send_plain(8'h12, 1'b0);
		send_plain(8'hF0, 1'b0);
		send_plain(8'hE4, 1'b0);
		// An empty packed run leaves the decoder at a header.
		send_plain(8'h80, 1'b0);
		// Raw run cut short by a separator.
		send_plain(8'h05, 1'b0);
		send_plain(8'h41, 1'b0);
		send_plain(SEP_BYTE, 1'b0);
		// A zero inside a packed run stops decoding until the buffer ends.
		send_plain(8'h84, 1'b0);
		send_plain(ZERO_BYTE, 1'b0);
		send_plain(8'h33, 1'b0);
		send_plain(RAW_HDR_MAX, 1'b0);
		send_plain(8'h44, 1'b1);
		// Longest raw header, abandoned by the buffer end on the same byte.
		send_plain(RAW_HDR_MAX, 1'b1);
		// Buffer end on a raw character gives the character, then the marker.
		send_plain(8'h02, 1'b0);
		send_plain(8'h55, 1'b1);
		// A zero header, then a separator that is also the buffer end.
		send_plain(ZERO_BYTE, 1'b0);
		send_plain(SEP_BYTE, 1'b1);
		// Ciphertext extremes.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	// Each cipher mode, the extreme sessions and the session whose key wraps to zero.
	task automatic test_session_modes();
		logic [47:0] sessions;
		sessions = {8'h3F, 8'hC0, 8'hFF, 8'h80, 8'h7F, 8'h00};
		for (int k = 0; k < 6; k++) begin
			set_session(sessions[k*8 +: 8]);
			send_plain(8'h02, 1'b0);
			send_plain(8'h30, 1'b0);
			send_plain(8'hCF, 1'b0);
			send_plain(8'h82, 1'b0);
			send_plain(8'h4E, 1'b0);
			send_plain(SEP_BYTE, 1'($urandom_range(0, 1)));
		end
	endtask

	// One packet of one to three runs, sometimes broken, or a burst of noise.
	task automatic send_random_packet();
		int unsigned runs;
		int unsigned cut_at;
		int unsigned sent;
		logic [7:0]  p;
		// Noise: arbitrary ciphertext with an occasional buffer end.
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6))
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			return;
		end
		runs = $urandom_range(1, 3);
		repeat (runs) begin
			// Mostly short runs, now and then a long or empty one.
			case ($urandom_range(0, 15))
				0:          p = 8'($urandom_range(1, RAW_HDR_MAX));
				1:          p = 8'($urandom_range(RAW_HDR_MAX + 1, SEP_BYTE - 1));
				2:          p = 8'h80;
				3, 4, 5, 6,
				7, 8:       p = 8'($urandom_range(1, 8));
				default:    p = 8'h80 | 8'($urandom_range(1, 10));
			endcase
			send_plain(p, 1'b0);
			cut_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 255;
			sent = 0;
			while ((phase_q == PH_RAW || phase_q == PH_PACKED) && sent < cut_at) begin
				if ($urandom_range(0, 39) == 0)
					p = ZERO_BYTE;
				else
					p = 8'($urandom_range(1, 254));
				send_plain(p, 1'b0);
				sent++;
			end
		end
		// The packet ends with a separator or with a buffer end on a last byte.
		if ($urandom_range(0, 1))
			send_plain(SEP_BYTE, $urandom_range(0, 3) == 0);
		else
			send_plain(8'($urandom_range(0, 254)), 1'b1);
	endtask

	// Random packets under several random sessions, some stretches without stalls.
	task automatic test_random_packets();
		int unsigned stop_at;
		for (int s = 0; s < RANDOM_PHASES; s++) begin
			set_session(8'($urandom_range(0, 255)));
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			stop_at = live_count + RANDOM_ITEMS / RANDOM_PHASES;
			while (live_count < stop_at)
				send_random_packet();
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'h00;
		in_valid = 1'b0;
		in_byte = 8'h00;
		buffer_last = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_session_modes();
		test_random_packets();
		wait_idle();

		$display("Decoded %0d live bytes into %0d checked items under %0d session writes.",
			live_count, checked_count, session_count);
		if (error_count == 0 && due_items.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
